// File: hdl/gce_pkg.sv
// Shared types and constants for the coefficient encoder.
package gce_pkg;

   localparam int LOW_BITS      = 7;
   localparam int MAX_CODE_BITS = 25;
   localparam int MAX_BYTES     = 6;
   localparam int CODE_W        = $clog2(MAX_CODE_BITS);
   localparam int COUNT_W       = $clog2(MAX_BYTES + 1);
   localparam int LOW_BUF_W     = 2 * LOW_BITS;
   localparam int LOW_CNT_W     = 3;
   localparam int UNARY_BUF_W   = 7;
   localparam int UNARY_OFF_W   = 3;
   localparam int GROUP_W       = 3;
   localparam int TOTAL_W       = 20;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic REGION_LOW   = 1'b0;
   localparam logic REGION_UNARY = 1'b1;

   typedef struct packed {
      logic       region;
      logic [7:0] data;
   } byte_type;

   // All bytes one request produces, in output order
   typedef struct packed {
      byte_type [MAX_BYTES-1:0] bytes;
      logic [COUNT_W-1:0]       count;
      logic                     last;
      logic                     err;
   } desc_type;

endpackage

// File: hdl/gce_front.sv
// Front end: splits each coefficient, packs low and unary bits, builds a byte list.
module gce_front import gce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [15:0] coefficient,
   input  logic        end_of_vector,
   output logic        desc_push,
   output desc_type    desc
);

   logic [LOW_BUF_W-1:0]   lb_ff, lb_in;
   logic [LOW_CNT_W-1:0]   lc_ff, lc_in;
   logic [UNARY_BUF_W-1:0] ub_ff, ub_in;
   logic [UNARY_OFF_W-1:0] uoff_ff, uoff_in;
   logic [GROUP_W-1:0]     grp_ff, grp_in;
   logic                   err_ff, err_in;

   logic signed [9:0] hi_ext, hval, hmag;
   logic [10:0]       n_raw;
   logic              clip;
   logic [CODE_W-1:0] n;
   logic [LOW_BUF_W-1:0] lacc, lb_next;
   logic [LOW_CNT_W:0]   lsum;
   logic [LOW_CNT_W-1:0] lc_next;
   logic                 lemit;
   logic [5:0]  pos, bits;
   logic [2:0]  nbytes;
   logic [2:0]  left;
   logic [39:0] uacc, ushift;
   logic [7:0]  uleft;
   logic [6:0]  cand_v;
   byte_type [6:0] cand_b;
   logic [COUNT_W-1:0] cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff   <= '0;
         lc_ff   <= '0;
         ub_ff   <= '0;
         uoff_ff <= '0;
         grp_ff  <= '0;
         err_ff  <= 1'b0;
      end else begin
         lb_ff   <= lb_in;
         lc_ff   <= lc_in;
         ub_ff   <= ub_in;
         uoff_ff <= uoff_in;
         grp_ff  <= grp_in;
         err_ff  <= err_in;
      end
   end

   always_comb begin
      // high part: v = h*128 + l, sign flipped when l is non-negative
      hi_ext = {coefficient[15], coefficient[15:7]};
      if (coefficient[LOW_BITS-1]) hval = hi_ext + 10'sd1;
      else                         hval = -hi_ext;
      hmag = -hval;
      if (hval[9]) n_raw = {hmag, 1'b0} - 11'd1;
      else         n_raw = {hval, 1'b0};
      clip = n_raw >= 11'(MAX_CODE_BITS);
      n    = clip ? CODE_W'(MAX_CODE_BITS - 1) : n_raw[CODE_W-1:0];

      // low part packing
      lacc    = lb_ff | (LOW_BUF_W'(coefficient[LOW_BITS-1:0]) << lc_ff);
      lsum    = {1'b0, lc_ff} + (LOW_CNT_W+1)'(LOW_BITS);
      lemit   = lsum >= (LOW_CNT_W+1)'(8);
      lb_next = lemit ? (lacc >> 8) : lacc;
      lc_next = lemit ? LOW_CNT_W'(lsum - (LOW_CNT_W+1)'(8)) : lsum[LOW_CNT_W-1:0];

      // unary code: n zeros then a one, after the pending bits
      pos    = 6'(n) + 6'(uoff_ff);
      bits   = pos + 6'd1;
      nbytes = bits[5:3];
      left   = bits[2:0];
      uacc   = 40'(ub_ff) | (40'd1 << pos);
      ushift = uacc >> {nbytes, 3'b000};
      uleft  = ushift[7:0];

      cand_v[0] = lemit;
      cand_b[0] = '{region: REGION_LOW, data: lacc[7:0]};
      for (int j = 0; j < 4; j++) begin
         cand_v[j+1] = nbytes > 3'(j);
         cand_b[j+1] = '{region: REGION_UNARY, data: uacc[8*j +: 8]};
      end
      cand_v[5] = end_of_vector && (lc_next != '0);
      cand_b[5] = '{region: REGION_LOW, data: lb_next[7:0]};
      cand_v[6] = end_of_vector && (left != '0);
      cand_b[6] = '{region: REGION_UNARY, data: uleft};

      desc = '0;
      cnt  = '0;
      for (int k = 0; k < 7; k++) begin
         if (cand_v[k] && (cnt < COUNT_W'(MAX_BYTES))) begin
            desc.bytes[cnt] = cand_b[k];
            cnt = cnt + COUNT_W'(1);
         end
      end
      desc.count = cnt;
      desc.last  = end_of_vector;
      desc.err   = err_ff | clip | (end_of_vector && (grp_ff != '1));
      desc_push  = accept && (cnt != '0);

      lb_in   = lb_ff;
      lc_in   = lc_ff;
      ub_in   = ub_ff;
      uoff_in = uoff_ff;
      grp_in  = grp_ff;
      err_in  = err_ff;
      if (accept) begin
         if (end_of_vector) begin
            lb_in   = '0;
            lc_in   = '0;
            ub_in   = '0;
            uoff_in = '0;
            grp_in  = '0;
            err_in  = 1'b0;
         end else begin
            lb_in   = lb_next;
            lc_in   = lc_next;
            ub_in   = uleft[UNARY_BUF_W-1:0];
            uoff_in = left;
            grp_in  = grp_ff + GROUP_W'(1);
            err_in  = desc.err;
         end
      end
   end

endmodule

// File: hdl/gce_queue.sv
// Short queue of byte lists between front and back end.
module gce_queue import gce_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output desc_type head
);

   desc_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_desc;
   end

   always_comb begin
      full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
      head_valid = cnt_ff != '0;
      head       = mem_ff[rd_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_in      = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in      = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in     = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

endmodule

// File: hdl/gce_back.sv
// Back end: walks each byte list into the output register, counts bytes per vector.
module gce_back import gce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  desc_type           head,
   output logic               head_pop,
   input  logic               pop,
   output logic               empty,
   output logic               region,
   output logic [7:0]         data_byte,
   output logic               final_byte,
   output logic               code_error,
   output logic [TOTAL_W-1:0] total_bytes
);

   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [TOTAL_W-1:0] cnt_ff, cnt_in;
   logic               ov_ff, ov_in;
   byte_type           ob_ff, ob_in;
   logic               ofin_ff, ofin_in;
   logic               oerr_ff, oerr_in;
   logic [TOTAL_W-1:0] otot_ff, otot_in;
   logic               advance, emit, is_end, is_final;
   logic [TOTAL_W-1:0] cnt_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      ob_ff   <= ob_in;
      ofin_ff <= ofin_in;
      oerr_ff <= oerr_in;
      otot_ff <= otot_in;
   end

   always_comb begin
      advance  = !ov_ff || pop;
      emit     = head_valid && advance;
      is_end   = idx_ff == (head.count - COUNT_W'(1));
      is_final = is_end && head.last;
      cnt_inc  = cnt_ff + TOTAL_W'(1);
      head_pop = emit && is_end;

      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      ov_in   = pop ? 1'b0 : ov_ff;
      ob_in   = ob_ff;
      ofin_in = ofin_ff;
      oerr_in = oerr_ff;
      otot_in = otot_ff;
      if (emit) begin
         idx_in  = is_end ? '0 : idx_ff + COUNT_W'(1);
         cnt_in  = is_final ? '0 : cnt_inc;
         ov_in   = 1'b1;
         ob_in   = head.bytes[idx_ff];
         ofin_in = is_final;
         oerr_in = head.err;
         otot_in = is_final ? cnt_inc : '0;
      end

      empty       = !ov_ff;
      region      = ob_ff.region;
      data_byte   = ob_ff.data;
      final_byte  = ofin_ff;
      code_error  = oerr_ff;
      total_bytes = otot_ff;
   end

endmodule

// File: hdl/gaussian_coeff_encoder.sv
// Top level of the split low-bit / unary high-part coefficient encoder.
//
//   Channel  Ports                                  Moves
//   request  push, full, req_*                      one coefficient and end flag
//   response empty, pop, rsp_*                      one encoded byte
//
// The front end takes a request every cycle while the internal queue has room.
// The back end sends one byte per cycle while the response port is popped, and a
// request yields 0 to 6 bytes.
// Reset is synchronous and clears all packing state, counters and the queue.
// A stalled response port fills the output register, then the queue (4 lists),
// then raises full.
module gaussian_coeff_encoder import gce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [15:0]        req_coefficient,
   input  logic               req_end_of_vector,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_region,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_final_byte,
   output logic               rsp_code_error,
   output logic [TOTAL_W-1:0] rsp_total_bytes
);

   logic     accept;
   logic     desc_push;
   desc_type desc;
   logic     head_valid;
   desc_type head;
   logic     head_pop;

   assign accept = push && !full;

   gce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .coefficient   (req_coefficient),
      .end_of_vector (req_end_of_vector),
      .desc_push     (desc_push),
      .desc          (desc)
   );

   gce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (desc_push),
      .push_desc  (desc),
      .pop        (head_pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   gce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop),
      .pop         (pop),
      .empty       (empty),
      .region      (rsp_region),
      .data_byte   (rsp_data_byte),
      .final_byte  (rsp_final_byte),
      .code_error  (rsp_code_error),
      .total_bytes (rsp_total_bytes)
   );

endmodule

// File: hdl/gce_checker.sv
// Port-level checks for the coefficient encoder, bound to the top level.
module gce_checker import gce_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               empty,
   input logic               pop,
   input logic [7:0]         rsp_data_byte,
   input logic               rsp_final_byte,
   input logic               rsp_code_error,
   input logic [TOTAL_W-1:0] rsp_total_bytes
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("response shown right after reset");

   a_total_on_final: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_final_byte) |-> (rsp_total_bytes != '0))
      else $error("final byte without a byte count");

   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_final_byte) |-> (rsp_total_bytes == '0))
      else $error("byte count on a non-final byte");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_code_error && !rsp_final_byte) |=> (empty || rsp_code_error))
      else $error("error flag dropped inside a vector");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data_byte)))
      else $error("stalled response changed");

endmodule

bind gaussian_coeff_encoder gce_checker u_gce_checker (
   .clock           (clock),
   .reset           (reset),
   .empty           (empty),
   .pop             (pop),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_final_byte  (rsp_final_byte),
   .rsp_code_error  (rsp_code_error),
   .rsp_total_bytes (rsp_total_bytes)
);
